[rtl/core/assert_macros.svh]
// assertion macros used by the checker file of the queue block
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

[rtl/core/mwq_pkg.sv]
// shared types, codes and sizes of the minimum-weight eviction queue
// no dependencies; imported by every module of the block
package mwq_pkg;

	// sizing
	localparam int CAPACITY  = 16;
	localparam int ID_BITS   = 16;
	localparam int ID_IN_W   = 16;
	localparam int WEIGHT_W  = 64;
	localparam int OCC_W     = 5;
	localparam int ID_W      = (ID_BITS < ID_IN_W) ? ID_BITS : ID_IN_W;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// stream widths
	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 88;
	localparam int M_TUSER_W = 3;
	localparam int M_PAD_W   = M_TDATA_W - (ID_IN_W + WEIGHT_W + OCC_W + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t               op;
		logic [ID_IN_W-1:0]    id;
		logic [WEIGHT_W-1:0]   weight;
	} cmd_t;

	typedef struct packed {
		status_t               status;
		logic                  out_valid;
		logic [ID_IN_W-1:0]    out_id;
		logic [WEIGHT_W-1:0]   out_weight;
		logic [OCC_W-1:0]      occupancy;
		logic                  below_min;
	} res_t;

endpackage

[rtl/core/mwq_store.sv]
// weight-sorted entry array: every cell compares against the item in parallel
// and shifts, keeps or loads in one step; depends on mwq_pkg
module mwq_store import mwq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cmd_t cmd,
	output res_t res
);

	typedef enum logic [1:0] {
		SEL_KEEP = 2'd0,
		SEL_NEXT = 2'd1,
		SEL_PREV = 2'd2,
		SEL_NEW  = 2'd3
	} cell_sel_t;

	// cells ordered by weight, equal weights oldest first; head is the minimum
	logic [CAPACITY-1:0]  valid_q;
	logic [ID_W-1:0]      id_q     [CAPACITY];
	logic [WEIGHT_W-1:0]  weight_q [CAPACITY];
	logic [CNT_W-1:0]     cnt_q;

	logic [ID_W-1:0]      cid;
	logic [CAPACITY-1:0]  le, id_hit, exact, upto;
	logic [CAPACITY:0]    le_ext, le_pre;
	logic                 full, empty, dup, found;
	logic                 do_ins, evict, pop_ok, rem_ok;

	cell_sel_t            sel      [CAPACITY];
	logic [CAPACITY-1:0]  up_valid, dn_valid, nxt_valid;
	logic [ID_W-1:0]      up_id    [CAPACITY];
	logic [ID_W-1:0]      dn_id    [CAPACITY];
	logic [ID_W-1:0]      nxt_id   [CAPACITY];
	logic [WEIGHT_W-1:0]  up_w     [CAPACITY];
	logic [WEIGHT_W-1:0]  dn_w     [CAPACITY];
	logic [WEIGHT_W-1:0]  nxt_w    [CAPACITY];
	logic [CNT_W-1:0]     cnt_nxt;

	logic [ID_W+ID_IN_W-1:0]  head_id_wide;
	logic [CNT_W+OCC_W-1:0]   occ_wide;

	assign cid = cmd.id[ID_W-1:0];

	// per-cell compares and neighbour taps
	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		assign le[gi]     = valid_q[gi] && (weight_q[gi] <= cmd.weight);
		assign id_hit[gi] = valid_q[gi] && (id_q[gi] == cid);
		assign exact[gi]  = id_hit[gi] && (weight_q[gi] == cmd.weight);
		assign upto[gi]   = |exact[gi:0];

		if (gi < CAPACITY - 1) begin : g_up
			assign up_valid[gi] = valid_q[gi+1];
			assign up_id[gi]    = id_q[gi+1];
			assign up_w[gi]     = weight_q[gi+1];
		end else begin : g_up_end
			assign up_valid[gi] = 1'b0;
			assign up_id[gi]    = id_q[gi];
			assign up_w[gi]     = weight_q[gi];
		end

		if (gi > 0) begin : g_dn
			assign dn_valid[gi] = valid_q[gi-1];
			assign dn_id[gi]    = id_q[gi-1];
			assign dn_w[gi]     = weight_q[gi-1];
		end else begin : g_dn_end
			assign dn_valid[gi] = valid_q[gi];
			assign dn_id[gi]    = id_q[gi];
			assign dn_w[gi]     = weight_q[gi];
		end

		// choose where this cell takes its next content from
		always_comb begin
			sel[gi] = SEL_KEEP;
			if (evict) begin
				if (le_ext[gi+1]) begin
					sel[gi] = SEL_NEXT;
				end else if (le[gi] || (gi == 0)) begin
					sel[gi] = SEL_NEW;
				end
			end else if (do_ins) begin
				if (!le[gi]) begin
					sel[gi] = le_pre[gi] ? SEL_NEW : SEL_PREV;
				end
			end else if (pop_ok) begin
				sel[gi] = SEL_NEXT;
			end else if (rem_ok && upto[gi]) begin
				sel[gi] = SEL_NEXT;
			end
		end

		// cell content mux
		always_comb begin
			case (sel[gi])
				SEL_NEXT: begin
					nxt_valid[gi] = up_valid[gi];
					nxt_id[gi]    = up_id[gi];
					nxt_w[gi]     = up_w[gi];
				end
				SEL_PREV: begin
					nxt_valid[gi] = dn_valid[gi];
					nxt_id[gi]    = dn_id[gi];
					nxt_w[gi]     = dn_w[gi];
				end
				SEL_NEW: begin
					nxt_valid[gi] = 1'b1;
					nxt_id[gi]    = cid;
					nxt_w[gi]     = cmd.weight;
				end
				default: begin
					nxt_valid[gi] = valid_q[gi];
					nxt_id[gi]    = id_q[gi];
					nxt_w[gi]     = weight_q[gi];
				end
			endcase
		end

		// cell payload, no reset needed
		always_ff @(posedge clk) begin
			if (step) begin
				id_q[gi]     <= nxt_id[gi];
				weight_q[gi] <= nxt_w[gi];
			end
		end
	end

	// le is a prefix mask over the sorted cells
	assign le_ext = {1'b0, le};
	assign le_pre = {le, 1'b1};

	// operation decode
	assign full   = valid_q[CAPACITY-1];
	assign empty  = !valid_q[0];
	assign dup    = |id_hit;
	assign found  = |exact;
	assign do_ins = (cmd.op == OP_INSERT) && !dup;
	assign evict  = do_ins && full;
	assign pop_ok = (cmd.op == OP_POP) && !empty;
	assign rem_ok = (cmd.op == OP_REMOVE) && found;

	// entry count after the step
	always_comb begin
		cnt_nxt = cnt_q;
		if (do_ins && !full) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (pop_ok || rem_ok) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	// valid bits and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			valid_q <= nxt_valid;
			cnt_q   <= cnt_nxt;
		end
	end

	// result of the item under way
	assign head_id_wide = {{ID_IN_W{1'b0}}, id_q[0]};
	assign occ_wide     = {{OCC_W{1'b0}}, cnt_nxt};

	always_comb begin
		case (cmd.op)
			OP_INSERT: res.status = dup ? ST_DUP : ST_OK;
			OP_POP:    res.status = empty ? ST_EMPTY : ST_OK;
			OP_REMOVE: res.status = found ? ST_OK : ST_NOT_FOUND;
			default:   res.status = ST_OK;
		endcase
		res.out_valid  = evict || pop_ok;
		res.out_id     = res.out_valid ? head_id_wide[ID_IN_W-1:0] : '0;
		res.out_weight = res.out_valid ? weight_q[0] : '0;
		res.occupancy  = occ_wide[OCC_W-1:0];
		res.below_min  = valid_q[0] && !le[0];
	end

endmodule

[rtl/core/min_weight_eviction_queue_unit.sv]
// minimum-weight eviction queue: an accepted item waits in the input register, is
// applied to the sorted cell array and has its result loaded into the output register
// for the master side; the queue takes one item per cycle unless the master side stalls,
// a rate set by the single-step update of the sorted cell array. Reset clears all
// entries and both pipeline valids at once.
// depends on mwq_pkg and mwq_store
module min_weight_eviction_queue_unit import mwq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // entry_id, weight
	input  logic [S_TUSER_W-1:0] s_tuser,   // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // out_id, out_weight, occupancy, below_min, pad
	output logic [M_TUSER_W-1:0] m_tuser    // status, out_valid
);

	cmd_t  cmd_s1;
	logic  vld_s1;
	res_t  res_s2;
	logic  vld_s2;
	res_t  res;
	logic  adv;

	// item moves into the output register when that register frees up
	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.op     <= opcode_t'(s_tuser[1:0]);
			cmd_s1.id     <= s_tdata[ID_IN_W-1:0];
			cmd_s1.weight <= s_tdata[ID_IN_W +: WEIGHT_W];
		end
	end

	// sorted entry array
	mwq_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.cmd    (cmd_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{M_PAD_W{1'b0}}, res_s2.below_min, res_s2.occupancy,
		res_s2.out_weight, res_s2.out_id};
	assign m_tuser  = {res_s2.out_valid, res_s2.status};

endmodule

[rtl/core/mwq_checker.sv]
// port-level checks on the result stream of the eviction queue, bound to the
// top level; depends on mwq_pkg and assert_macros.svh
`include "assert_macros.svh"

module mwq_checker import mwq_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	status_t              st;
	logic                 out_valid;
	logic [ID_IN_W-1:0]   out_id;
	logic [WEIGHT_W-1:0]  out_weight;
	logic [OCC_W-1:0]     occupancy;

	// field unpacking
	assign st         = status_t'(m_tuser[1:0]);
	assign out_valid  = m_tuser[2];
	assign out_id     = m_tdata[ID_IN_W-1:0];
	assign out_weight = m_tdata[ID_IN_W +: WEIGHT_W];
	assign occupancy  = m_tdata[ID_IN_W+WEIGHT_W +: OCC_W];

	// a stalled result holds
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// an empty pop leaves nothing held and reports no entry
	`ASSERT_IMPL(a_empty_pop, clk, arst_n, m_tvalid && st == ST_EMPTY, !out_valid && occupancy == OCC_W'(0))

	// a popped or evicted entry only comes with a plain ok
	`ASSERT_IMPL(a_out_ok, clk, arst_n, m_tvalid && out_valid, st == ST_OK)

	// without an entry out the entry fields are zero
	`ASSERT_IMPL(a_out_zero, clk, arst_n, m_tvalid && !out_valid, out_id == '0 && out_weight == '0)

endmodule

bind min_weight_eviction_queue_unit mwq_checker u_mwq_checker (.*);

[bench/min_weight_eviction_queue_unit_tb.sv]
// self-checking bench for the minimum-weight eviction queue: directed table then random items
// depends on mwq_pkg and the min_weight_eviction_queue_unit rtl; no files or arguments
module min_weight_eviction_queue_unit_tb;
	import mwq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1350;
	localparam logic [ID_IN_W-1:0] ID_KEY_MASK = ID_IN_W'((64'd1 << ID_W) - 64'd1);

	// master-side field offsets
	localparam int OUT_WT_LO = ID_IN_W;
	localparam int OCC_LO    = ID_IN_W + WEIGHT_W;
	localparam int BELOW_BIT = OCC_LO + OCC_W;

	typedef struct {
		opcode_t               op;
		logic [ID_IN_W-1:0]    id;
		logic [WEIGHT_W-1:0]   wt;
		bit                    typed;
		res_t                  want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// shadow of the held entries, oldest first
	logic [ID_IN_W-1:0]  held_id[$];
	logic [WEIGHT_W-1:0] held_wt[$];

	res_t      pending_res[$];
	stim_row_t dir_tbl[$];

	bit quiet = 1'b0;
	int cycles = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int n_unexpected = 0;
	int n_evict = 0;
	int n_dup = 0;
	int n_miss = 0;
	int n_empty = 0;
	int n_full = 0;

	min_weight_eviction_queue_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// oldest entry among those of least weight; caller ensures the set is not empty
	function automatic int oldest_min();
		int best;
		best = 0;
		for (int i = 1; i < held_wt.size(); i++) begin
			if (held_wt[i] < held_wt[best])
				best = i;
		end
		return best;
	endfunction

	// applies one operation to the shadow set and returns the result it should give
	function automatic res_t predict_queue_op(opcode_t op, logic [ID_IN_W-1:0] id_in,
			logic [WEIGHT_W-1:0] w);
		res_t r;
		logic [ID_IN_W-1:0] key;
		int m;
		int hit;
		r = '0;
		r.status = ST_OK;
		key = id_in & ID_KEY_MASK;
		if (held_wt.size() > 0 && w < held_wt[oldest_min()])
			r.below_min = 1'b1;
		case (op)
			OP_INSERT: begin
				hit = 0;
				foreach (held_id[i])
					if (held_id[i] == key)
						hit = 1;
				if (hit != 0) begin
					r.status = ST_DUP;
					n_dup++;
				end else begin
					if (held_id.size() >= CAPACITY) begin
						m = oldest_min();
						r.out_valid = 1'b1;
						r.out_id = held_id[m];
						r.out_weight = held_wt[m];
						held_id.delete(m);
						held_wt.delete(m);
						n_evict++;
					end
					held_id = {held_id, key};
					held_wt = {held_wt, w};
				end
			end
			OP_POP: begin
				if (held_id.size() == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					m = oldest_min();
					r.out_valid = 1'b1;
					r.out_id = held_id[m];
					r.out_weight = held_wt[m];
					held_id.delete(m);
					held_wt.delete(m);
				end
			end
			OP_REMOVE: begin
				hit = -1;
				foreach (held_id[i])
					if (hit < 0 && held_id[i] == key && held_wt[i] == w)
						hit = i;
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
					n_miss++;
				end else begin
					held_id.delete(hit);
					held_wt.delete(hit);
				end
			end
			default: ;
		endcase
		if (held_id.size() == CAPACITY)
			n_full++;
		r.occupancy = OCC_W'(held_id.size());
		return r;
	endfunction

	function automatic res_t make_res(status_t st, bit ov, logic [ID_IN_W-1:0] oid,
			logic [WEIGHT_W-1:0] ow, int occ, bit below);
		res_t r;
		r.status = st;
		r.out_valid = ov;
		r.out_id = oid;
		r.out_weight = ow;
		r.occupancy = OCC_W'(occ);
		r.below_min = below;
		return r;
	endfunction

	function automatic void add_row(opcode_t op, logic [ID_IN_W-1:0] id, logic [WEIGHT_W-1:0] wt,
			bit typed, res_t want);
		stim_row_t row;
		row.op = op;
		row.id = id;
		row.wt = wt;
		row.typed = typed;
		row.want = want;
		dir_tbl = {dir_tbl, row};
	endfunction

	// offers one item at a falling edge, holds it until accepted, then logs what it should give
	task automatic drive_item(opcode_t op, logic [ID_IN_W-1:0] id, logic [WEIGHT_W-1:0] wt,
			bit typed, res_t want);
		int gap;
		res_t pred;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {wt, id};
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		pred = predict_queue_op(op, id, wt);
		if (typed)
			pred = want;
		pending_res = {pending_res, pred};
		n_sent++;
		@(negedge clk);
	endtask

	// result side: draws a stall after each accepted result
	initial begin : ready_drive
		int rx_mark;
		int rx_hold;
		rx_mark = 0;
		rx_hold = 0;
		forever begin
			@(negedge clk);
			if (n_checked != rx_mark) begin
				rx_mark = n_checked;
				rx_hold = quiet ? 0 : $urandom_range(0, 5);
			end
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each accepted result with the oldest one outstanding
	always @(posedge clk) begin : result_check
		res_t got;
		res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser[1:0]);
			got.out_valid = m_tuser[2];
			got.out_id = m_tdata[ID_IN_W-1:0];
			got.out_weight = m_tdata[OUT_WT_LO +: WEIGHT_W];
			got.occupancy = m_tdata[OCC_LO +: OCC_W];
			got.below_min = m_tdata[BELOW_BIT];
			n_checked++;
			if (pending_res.size() == 0) begin
				n_unexpected++;
				if (n_mismatch + n_unexpected <= 10)
					$display("unexpected result: status %0d id %h weight %h occ %0d",
						got.status, got.out_id, got.out_weight, got.occupancy);
			end else begin
				exp_r = pending_res.pop_front();
				if (got.status !== exp_r.status || got.out_valid !== exp_r.out_valid ||
						got.out_id !== exp_r.out_id || got.out_weight !== exp_r.out_weight ||
						got.occupancy !== exp_r.occupancy || got.below_min !== exp_r.below_min) begin
					n_mismatch++;
					if (n_mismatch + n_unexpected <= 10) begin
						$display("mismatch at result %0d: expected st %0d ov %0d id %h wt %h occ %0d below %0d",
							n_checked, exp_r.status, exp_r.out_valid, exp_r.out_id,
							exp_r.out_weight, exp_r.occupancy, exp_r.below_min);
						$display("                      actual   st %0d ov %0d id %h wt %h occ %0d below %0d",
							got.status, got.out_valid, got.out_id, got.out_weight,
							got.occupancy, got.below_min);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_res.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		opcode_t op;
		logic [ID_IN_W-1:0] id;
		logic [WEIGHT_W-1:0] wt;
		int pick;
		int idx;
		int mix;
		res_t none;
		none = '0;

		// empty set, no-op, extremes of id and weight, duplicate and exact-match removal
		add_row(OP_POP, 16'h0000, 64'd0, 1, make_res(ST_EMPTY, 0, 0, 0, 0, 0));
		add_row(OP_NOP, 16'h1234, '1, 1, make_res(ST_OK, 0, 0, 0, 0, 0));
		add_row(OP_REMOVE, 16'hffff, 64'd0, 1, make_res(ST_NOT_FOUND, 0, 0, 0, 0, 0));
		add_row(OP_INSERT, 16'h0000, '1, 1, make_res(ST_OK, 0, 0, 0, 1, 0));
		add_row(OP_INSERT, 16'hffff, 64'd0, 1, make_res(ST_OK, 0, 0, 0, 2, 1));
		add_row(OP_INSERT, 16'h0000, 64'd7, 1, make_res(ST_DUP, 0, 0, 0, 2, 0));
		add_row(OP_REMOVE, 16'hffff, 64'd1, 1, make_res(ST_NOT_FOUND, 0, 0, 0, 2, 0));
		add_row(OP_REMOVE, 16'hffff, 64'd0, 1, make_res(ST_OK, 0, 0, 0, 1, 0));
		add_row(OP_POP, 16'h0000, '1, 1, make_res(ST_OK, 1, 16'h0000, '1, 0, 0));
		// fill to capacity with equal weights, then evict the oldest of them
		for (int k = 1; k <= CAPACITY; k++)
			add_row(OP_INSERT, ID_IN_W'(k), 64'd100, 0, none);
		add_row(OP_INSERT, 16'h0100, 64'd50, 1,
			make_res(ST_OK, 1, 16'h0001, 64'd100, CAPACITY, 1));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tbl[k])
			drive_item(dir_tbl[k].op, dir_tbl[k].id, dir_tbl[k].wt, dir_tbl[k].typed,
				dir_tbl[k].want);

		// random part: phases lean towards filling, churning or draining the set
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			// sender goes idle until every outstanding result is back
			if (n == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (pending_res.size() != 0)
					@(negedge clk);
			end
			mix = (n / 150) % 3;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				op = OP_NOP;
			else if (pick < (mix == 0 ? 75 : mix == 1 ? 50 : 30))
				op = OP_INSERT;
			else if (pick < (mix == 0 ? 85 : mix == 1 ? 75 : 80))
				op = OP_POP;
			else
				op = OP_REMOVE;

			id = ($urandom_range(0, 99) < 85) ? ID_IN_W'($urandom_range(0, 23))
				: ID_IN_W'($urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			if (pick < 45)
				wt = WEIGHT_W'($urandom_range(0, 40));
			else if (pick < 90)
				wt = {$urandom, $urandom};
			else
				wt = ($urandom_range(0, 1) != 0) ? '1 : '0;

			// most removes aim at an entry that is held, some just miss its weight
			if (op == OP_REMOVE && held_id.size() > 0 && $urandom_range(0, 99) < 65) begin
				idx = $urandom_range(0, held_id.size() - 1);
				id = held_id[idx];
				wt = held_wt[idx];
				if ($urandom_range(0, 9) == 0)
					wt = wt + 64'd1;
			end
			drive_item(op, id, wt, 0, none);
		end

		s_tvalid <= 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		$display("ran %0d items: %0d evictions, %0d duplicate inserts, %0d missed removes,",
			n_sent, n_evict, n_dup, n_miss);
		$display("%0d pops on an empty set, %0d items ending full; %0d results checked",
			n_empty, n_full, n_checked);
		if (n_mismatch == 0 && n_unexpected == 0 && pending_res.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d unexpected results", n_mismatch, n_unexpected);
			$display("FAIL");
		end
		$finish;
	end

endmodule
